### src/aog_pkg.sv
// Shared types, codes and constants for the adaptive overload guard.
// No dependencies; every other file refers to it by scoped names.
package aog_pkg;

  // Field widths.
  localparam int ACTION_W = 2;
  localparam int FRAME_W  = 12;
  localparam int OBJ_W    = 10;
  localparam int KIND_W   = 3;
  localparam int ALERT_W  = 2;
  localparam int SCORE_W  = 7;
  localparam int LIM_W    = 10;
  localparam int AVG_W    = 12;
  localparam int MS_W     = 13;
  localparam int RUN_W    = 8;
  localparam int EMF_W    = 8;

  localparam int COUNTER_BITS_DEF = 16;

  // Action codes.
  localparam logic [ACTION_W-1:0] ACT_FRAME  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_RECORD = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CHECK  = 2'd2;

  // Action kinds.
  localparam logic [KIND_W-1:0] KIND_OTHER    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SPELL    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_MELEE    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CLEANUP  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_MOVE     = 3'd4;
  localparam logic [KIND_W-1:0] KIND_CREATE   = 3'd5;
  localparam logic [KIND_W-1:0] KIND_STAND    = 3'd6;
  localparam logic [KIND_W-1:0] KIND_MODE     = 3'd7;

  // Alert levels.
  localparam logic [ALERT_W-1:0] ALERT_NORMAL   = 2'd0;
  localparam logic [ALERT_W-1:0] ALERT_CAUTION  = 2'd1;
  localparam logic [ALERT_W-1:0] ALERT_WARNING  = 2'd2;
  localparam logic [ALERT_W-1:0] ALERT_CRITICAL = 2'd3;

  // Reset values.
  localparam logic [EMF_W-1:0]   EMF_RESET   = 8'd45;
  localparam logic [SCORE_W-1:0] SCORE_MAX   = 7'd100;
  localparam logic [SCORE_W-1:0] SCORE_MIN   = 7'd30;
  localparam logic [LIM_W-1:0]   OBJ_RESET   = 10'd400;
  localparam logic [LIM_W-1:0]   SPELL_RESET = 10'd108;
  localparam logic [LIM_W-1:0]   MELEE_RESET = 10'd128;
  localparam logic [LIM_W-1:0]   TOTAL_RESET = 10'd210;

  // Limit offsets.
  localparam logic [LIM_W-1:0] OBJ_BASE   = 10'd200;
  localparam logic [LIM_W-1:0] SPELL_BASE = 10'd60;
  localparam logic [LIM_W-1:0] MELEE_BASE = 10'd80;
  localparam logic [LIM_W-1:0] TOTAL_BASE = 10'd150;

  localparam logic [AVG_W-1:0] AVG_FAST = 12'd16;
  localparam logic [AVG_W-1:0] AVG_SLOW = 12'd33;
  localparam logic [MS_W:0]    MS_SECOND = 14'd1000;

  // Shared multiply-add unit: p = a * b + c.
  localparam int MAC_A_W = 16;
  localparam int MAC_B_W = 20;
  localparam int MAC_C_W = 12;
  localparam int MAC_P_W = 37;

  typedef struct packed {
    logic [MAC_A_W-1:0] a;
    logic [MAC_B_W-1:0] b;
    logic [MAC_C_W-1:0] c;
  } mac_req_t;

  // Multipliers. The reciprocals give exact floors over the ranges used:
  // x/10 = x*52429 >> 19 for 16-bit x, x/100 = x*5243 >> 19 for x below 6000,
  // x/17 = x*241 >> 12 for x below 1200.
  localparam logic [MAC_B_W-1:0] K_NINE      = 20'd9;
  localparam logic [MAC_B_W-1:0] K_RECIP_10  = 20'd52429;
  localparam logic [MAC_B_W-1:0] K_SCORE     = 20'd16870;   // 70 * 241
  localparam logic [MAC_B_W-1:0] K_SPELL     = 20'd251664;  // 48 * 5243
  localparam logic [MAC_B_W-1:0] K_TOTAL     = 20'd314580;  // 60 * 5243
  localparam logic [MAC_B_W-1:0] K_RECIP_100 = 20'd5243;

  localparam int DIV_SH   = 19;
  localparam int SCORE_SH = 12;

endpackage

### src/aog_item_if.sv
// Input channel of the overload guard: valid/ready handshake and item fields.
// Depends on aog_pkg for field widths.
interface aog_item_if;
  logic                         valid;
  logic                         ready;
  logic [aog_pkg::ACTION_W-1:0] action;
  logic [aog_pkg::FRAME_W-1:0]  frame_ms;
  logic [aog_pkg::OBJ_W-1:0]    object_count;
  logic [aog_pkg::KIND_W-1:0]   kind;

  modport source (output valid, action, frame_ms, object_count, kind, input ready);
  modport sink (input valid, action, frame_ms, object_count, kind, output ready);
endinterface

### src/aog_result_if.sv
// Output channel of the overload guard: valid/ready handshake and result fields.
// Depends on aog_pkg for field widths.
interface aog_result_if;
  logic                        valid;
  logic                        ready;
  logic                        allowed;
  logic [aog_pkg::ALERT_W-1:0] alert_level;
  logic                        emergency;
  logic [aog_pkg::SCORE_W-1:0] performance_score;
  logic [aog_pkg::OBJ_W-1:0]   remove_count;
  logic [aog_pkg::LIM_W-1:0]   object_limit;

  modport source (output valid, allowed, alert_level, emergency, performance_score,
                  remove_count, object_limit, input ready);
  modport sink (input valid, allowed, alert_level, emergency, performance_score,
                remove_count, object_limit, output ready);
endinterface

### src/aog_cfg_if.sv
// Configuration write channel of the overload guard: valid/ready and data.
// Depends on aog_pkg for the register width.
interface aog_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [aog_pkg::EMF_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

### src/adaptive_overload_guard.sv
// Adaptive overload guard, top level: sequencer, state registers and result register.
// Depends on aog_pkg, aog_item_if, aog_result_if, aog_cfg_if and aog_mac.
//
// Usage. Words enter on the item channel and every word yields exactly one
// word on the result channel, in order. A frame word smooths the frame time,
// rescales the score and limits, handles the one-second counter clear, grades
// the alert level and runs the emergency hysteresis. A record word bumps the
// saturating action counters, and a check word asks whether a kind of action
// is allowed right now. The cfg channel writes the count of consecutive
// critical frames needed for emergency entry; it is always ready and should
// only be written while no item is in flight.
// Sequencing. Every frame step goes through one shared multiply-add unit: 5 steps
// for the average, score and limits, then 9 threshold steps. The item channel
// is ready only in the idle state, one word at a time. Reset (synchronous,
// active high) restores score 100, its limits, zeroed counters and a register
// value of 45. If the receiver stalls, the finished result waits in the output
// register and the next word may still be taken and worked up to its result,
// which then waits until the register frees.
module adaptive_overload_guard #(
  parameter int COUNTER_BITS = aog_pkg::COUNTER_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  aog_item_if.sink      item,
  aog_result_if.source  result,
  aog_cfg_if.sink       cfg
);

  localparam int CMP_W = (COUNTER_BITS > aog_pkg::LIM_W) ? COUNTER_BITS : aog_pkg::LIM_W;

  // Threshold groups and grades walked by the threshold steps.
  localparam logic [1:0] GRP_OBJ   = 2'd0;
  localparam logic [1:0] GRP_SPELL = 2'd1;
  localparam logic [1:0] GRP_TOTAL = 2'd2;
  localparam logic [1:0] GRP_END   = 2'd3;
  localparam logic [1:0] GRD_CRIT  = 2'd0;
  localparam logic [1:0] GRD_WARN  = 2'd1;
  localparam logic [1:0] GRD_CAUT  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SUM, ST_DIV, ST_SCORE, ST_SPELL, ST_TOTAL, ST_THR, ST_DONE
  } state_t;

  state_t state;

  // Item registers.
  logic [aog_pkg::ACTION_W-1:0] act;
  logic [aog_pkg::KIND_W-1:0]   kind_r;
  logic [aog_pkg::FRAME_W-1:0]  frame_r;

  // Guard state.
  logic [aog_pkg::EMF_W-1:0]   emergency_frames;
  logic [aog_pkg::AVG_W-1:0]   avg_frame_ms;
  logic [aog_pkg::SCORE_W-1:0] perf_score;
  logic [aog_pkg::MS_W-1:0]    ms_since_clear;
  logic [COUNTER_BITS-1:0]     spell_count;
  logic [COUNTER_BITS-1:0]     melee_count;
  logic [COUNTER_BITS-1:0]     total_count;
  logic [aog_pkg::OBJ_W-1:0]   objects_now;
  logic [aog_pkg::ALERT_W-1:0] alert_now;
  logic                        emergency_on;
  logic [aog_pkg::RUN_W-1:0]   critical_run;
  logic [aog_pkg::LIM_W-1:0]   obj_lim;
  logic [aog_pkg::LIM_W-1:0]   spell_lim;
  logic [aog_pkg::LIM_W-1:0]   melee_lim;
  logic [aog_pkg::LIM_W-1:0]   total_lim;

  // Threshold walk: the step being issued and the one whose product is back.
  logic [1:0] thr_grp;
  logic [1:0] thr_grd;
  logic       pend_v;
  logic [1:0] pend_grp;
  logic [1:0] pend_grd;
  logic [2:0] over;   // indexed by grade: critical, warning, caution

  aog_pkg::mac_req_t            mac_req;
  logic [aog_pkg::MAC_P_W-1:0]  mac_p;

  aog_mac u_mac (
    .clk (clk),
    .req (mac_req),
    .p   (mac_p)
  );

  // Product fields.
  logic [aog_pkg::AVG_W-1:0]   avg_new;
  logic [aog_pkg::SCORE_W-1:0] score_q;
  logic [aog_pkg::LIM_W-1:0]   lim_q;
  logic [aog_pkg::SCORE_W-1:0] score_new;

  assign avg_new = mac_p[aog_pkg::DIV_SH +: aog_pkg::AVG_W];
  assign score_q = mac_p[aog_pkg::SCORE_SH +: aog_pkg::SCORE_W];
  assign lim_q   = mac_p[aog_pkg::DIV_SH +: aog_pkg::LIM_W];

  always_comb begin
    if (avg_frame_ms <= aog_pkg::AVG_FAST) begin
      score_new = aog_pkg::SCORE_MAX;
    end else if (avg_frame_ms >= aog_pkg::AVG_SLOW) begin
      score_new = aog_pkg::SCORE_MIN;
    end else begin
      score_new = aog_pkg::SCORE_MAX - score_q;
    end
  end

  // A ratio test count > L*num/den reduces to count > L - ceil(L*(den-num)/den).
  // The ceiling is taken as floor((y + 99)/100), halved again for the 0.995 test.
  logic [aog_pkg::LIM_W-1:0] thr_l;
  logic [aog_pkg::FRAME_W-1:0] thr_y;

  always_comb begin
    unique case (thr_grp)
      GRP_SPELL: thr_l = spell_lim;
      GRP_TOTAL: thr_l = total_lim;
      default:   thr_l = obj_lim;
    endcase
    unique case (thr_grd)
      GRD_CRIT: thr_y = aog_pkg::FRAME_W'(thr_l) + 12'd199;
      GRD_WARN: thr_y = aog_pkg::FRAME_W'(thr_l) + 12'd99;
      default:  thr_y = 12'd3 * aog_pkg::FRAME_W'(thr_l) + 12'd99;
    endcase
  end

  logic [aog_pkg::LIM_W-1:0] pend_l;
  logic [aog_pkg::LIM_W-1:0] thr_val;
  logic [CMP_W-1:0]          pend_cnt;
  logic                      pend_over;

  always_comb begin
    unique case (pend_grp)
      GRP_SPELL: begin
        pend_l   = spell_lim;
        pend_cnt = CMP_W'(spell_count);
      end
      GRP_TOTAL: begin
        pend_l   = total_lim;
        pend_cnt = CMP_W'(total_count);
      end
      default: begin
        pend_l   = obj_lim;
        pend_cnt = CMP_W'(objects_now);
      end
    endcase
    thr_val   = pend_l - ((pend_grd == GRD_CRIT) ? (lim_q >> 1) : lim_q);
    pend_over = pend_cnt > CMP_W'(thr_val);
  end

  // Operand selection for the shared unit.
  always_comb begin
    mac_req = '0;
    unique case (state)
      ST_SUM: begin
        mac_req.a = aog_pkg::MAC_A_W'(avg_frame_ms);
        mac_req.b = aog_pkg::K_NINE;
        mac_req.c = frame_r;
      end
      ST_DIV: begin
        mac_req.a = mac_p[aog_pkg::MAC_A_W-1:0];
        mac_req.b = aog_pkg::K_RECIP_10;
      end
      ST_SCORE: begin
        // Only meaningful when the new average lies strictly between the bounds.
        mac_req.a = aog_pkg::MAC_A_W'(5'(avg_new - aog_pkg::AVG_FAST));
        mac_req.b = aog_pkg::K_SCORE;
      end
      ST_SPELL: begin
        mac_req.a = aog_pkg::MAC_A_W'(score_new);
        mac_req.b = aog_pkg::K_SPELL;
      end
      ST_TOTAL: begin
        mac_req.a = aog_pkg::MAC_A_W'(perf_score);
        mac_req.b = aog_pkg::K_TOTAL;
      end
      ST_THR: begin
        mac_req.a = aog_pkg::MAC_A_W'(thr_y);
        mac_req.b = aog_pkg::K_RECIP_100;
      end
      default: mac_req = '0;
    endcase
  end

  // Frame conclusion: grade, critical run, emergency entry and exit.
  logic [aog_pkg::ALERT_W-1:0] level;
  logic [aog_pkg::RUN_W-1:0]   run_inc;
  logic                        enter;
  logic                        em_next;
  logic [aog_pkg::OBJ_W-1:0]   removal;

  always_comb begin
    priority if (over[GRD_CRIT]) begin
      level = aog_pkg::ALERT_CRITICAL;
    end else if (over[GRD_WARN]) begin
      level = aog_pkg::ALERT_WARNING;
    end else if (over[GRD_CAUT]) begin
      level = aog_pkg::ALERT_CAUTION;
    end else begin
      level = aog_pkg::ALERT_NORMAL;
    end
    run_inc = (critical_run == '1) ? critical_run : critical_run + 1'b1;
    enter   = (level == aog_pkg::ALERT_CRITICAL) && (run_inc >= emergency_frames) &&
              !emergency_on;
    if (level == aog_pkg::ALERT_CRITICAL) begin
      em_next = emergency_on || enter;
    end else if (level == aog_pkg::ALERT_WARNING) begin
      em_next = emergency_on;
    end else begin
      em_next = 1'b0;
    end
    if (enter && (objects_now > obj_lim)) begin
      removal = objects_now - (obj_lim >> 1);
    end else begin
      removal = '0;
    end
  end

  // Check answer.
  logic allowed_c;

  always_comb begin
    unique case (kind_r)
      aog_pkg::KIND_CREATE: allowed_c = objects_now < obj_lim;
      aog_pkg::KIND_STAND:  allowed_c = 1'b1;
      aog_pkg::KIND_MODE:   allowed_c = !emergency_on;
      aog_pkg::KIND_SPELL:
        allowed_c = !emergency_on && (CMP_W'(spell_count) < CMP_W'(spell_lim));
      aog_pkg::KIND_MELEE:
        allowed_c = !emergency_on && (CMP_W'(melee_count) < CMP_W'(melee_lim));
      aog_pkg::KIND_CLEANUP, aog_pkg::KIND_MOVE:
        allowed_c = emergency_on || (CMP_W'(total_count) < CMP_W'(total_lim));
      default:
        allowed_c = !emergency_on && (CMP_W'(total_count) < CMP_W'(total_lim));
    endcase
  end

  logic [aog_pkg::MS_W:0] ms_sum;
  assign ms_sum = (aog_pkg::MS_W + 1)'(ms_since_clear) + (aog_pkg::MS_W + 1)'(item.frame_ms);

  assign item.ready = (state == ST_IDLE);
  assign cfg.ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      emergency_frames <= aog_pkg::EMF_RESET;
      avg_frame_ms     <= '0;
      perf_score       <= aog_pkg::SCORE_MAX;
      ms_since_clear   <= '0;
      spell_count      <= '0;
      melee_count      <= '0;
      total_count      <= '0;
      objects_now      <= '0;
      alert_now        <= aog_pkg::ALERT_NORMAL;
      emergency_on     <= 1'b0;
      critical_run     <= '0;
      obj_lim          <= aog_pkg::OBJ_RESET;
      spell_lim        <= aog_pkg::SPELL_RESET;
      melee_lim        <= aog_pkg::MELEE_RESET;
      total_lim        <= aog_pkg::TOTAL_RESET;
      thr_grp          <= GRP_OBJ;
      thr_grd          <= GRD_CRIT;
      pend_v           <= 1'b0;
      over             <= '0;
      result.valid     <= 1'b0;
    end else begin
      if (cfg.valid) begin
        emergency_frames <= cfg.data;
      end
      if (result.valid && result.ready) begin
        result.valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (item.valid) begin
            act     <= item.action;
            kind_r  <= item.kind;
            frame_r <= item.frame_ms;
            if (item.action == aog_pkg::ACT_FRAME) begin
              // The second clear and the object sample come before the alert
              // grading, so they can be settled right away.
              objects_now <= item.object_count;
              if (ms_sum >= aog_pkg::MS_SECOND) begin
                ms_since_clear <= '0;
                spell_count    <= '0;
                melee_count    <= '0;
                total_count    <= '0;
              end else begin
                ms_since_clear <= aog_pkg::MS_W'(ms_sum);
              end
              over    <= '0;
              thr_grp <= GRP_OBJ;
              thr_grd <= GRD_CRIT;
              pend_v  <= 1'b0;
              state   <= ST_SUM;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_SUM: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          state <= ST_SCORE;
        end
        ST_SCORE: begin
          avg_frame_ms <= avg_new;
          state        <= ST_SPELL;
        end
        ST_SPELL: begin
          perf_score <= score_new;
          obj_lim    <= aog_pkg::OBJ_BASE + {score_new[aog_pkg::LIM_W-2:0], 1'b0};
          state      <= ST_TOTAL;
        end
        ST_TOTAL: begin
          spell_lim <= aog_pkg::SPELL_BASE + lim_q;
          melee_lim <= aog_pkg::MELEE_BASE + lim_q;
          state     <= ST_THR;
        end
        ST_THR: begin
          if (!pend_v) begin
            total_lim <= aog_pkg::TOTAL_BASE + lim_q;
          end else if (pend_over) begin
            over[pend_grd] <= 1'b1;
          end
          if (thr_grp == GRP_END) begin
            pend_v <= 1'b0;
            state  <= ST_DONE;
          end else begin
            pend_v   <= 1'b1;
            pend_grp <= thr_grp;
            pend_grd <= thr_grd;
            if (thr_grd == GRD_CAUT) begin
              thr_grd <= GRD_CRIT;
              thr_grp <= thr_grp + 1'b1;
            end else begin
              thr_grd <= thr_grd + 1'b1;
            end
          end
        end
        ST_DONE: begin
          if (!result.valid || result.ready) begin
            result.valid             <= 1'b1;
            result.allowed           <= (act == aog_pkg::ACT_CHECK) ? allowed_c : 1'b1;
            result.performance_score <= perf_score;
            result.object_limit      <= obj_lim;
            result.remove_count      <= '0;
            result.alert_level       <= alert_now;
            result.emergency         <= emergency_on;
            if (act == aog_pkg::ACT_FRAME) begin
              alert_now                <= level;
              emergency_on             <= em_next;
              critical_run             <= (level == aog_pkg::ALERT_CRITICAL) ? run_inc : '0;
              result.alert_level       <= level;
              result.emergency         <= em_next;
              result.remove_count      <= removal;
              if (enter) begin
                spell_count <= '0;
                melee_count <= '0;
                total_count <= '0;
              end
            end else if (act == aog_pkg::ACT_RECORD) begin
              total_count <= (total_count == '1) ? total_count : total_count + 1'b1;
              if (kind_r == aog_pkg::KIND_SPELL) begin
                spell_count <= (spell_count == '1) ? spell_count : spell_count + 1'b1;
              end else if (kind_r == aog_pkg::KIND_MELEE) begin
                melee_count <= (melee_count == '1) ? melee_count : melee_count + 1'b1;
              end
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // The object limit always follows the score once a frame has settled.
  a_obj_lim_tracks_score: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |->
      (obj_lim == aog_pkg::OBJ_BASE + {perf_score[aog_pkg::LIM_W-2:0], 1'b0}))
    else $error("object limit out of step with the score");

  // Melee and spell limits share one quotient and differ by a fixed offset.
  a_melee_spell_gap: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |->
      (melee_lim - spell_lim == aog_pkg::MELEE_BASE - aog_pkg::SPELL_BASE))
    else $error("melee and spell limits disagree");

  a_score_range: assert property (@(posedge clk) disable iff (rst)
    (perf_score >= aog_pkg::SCORE_MIN) && (perf_score <= aog_pkg::SCORE_MAX))
    else $error("score outside its range");

  // Emergency is only ever entered on a critical frame.
  a_entry_on_critical: assert property (@(posedge clk) disable iff (rst)
    $rose(emergency_on) |-> (alert_now == aog_pkg::ALERT_CRITICAL))
    else $error("emergency entered without a critical alert");

  // A removal request only comes with emergency entry.
  a_removal_in_emergency: assert property (@(posedge clk) disable iff (rst)
    (result.valid && (result.remove_count != '0)) |-> result.emergency)
    else $error("removal requested outside emergency");

endmodule

### src/aog_mac.sv
// Shared multiply-add unit with a registered product.
// Depends on aog_pkg for the request type and widths.
module aog_mac (
  input  logic                          clk,
  input  aog_pkg::mac_req_t             req,
  output logic [aog_pkg::MAC_P_W-1:0]   p
);

  always_ff @(posedge clk) begin
    p <= aog_pkg::MAC_P_W'(req.a) * aog_pkg::MAC_P_W'(req.b) + aog_pkg::MAC_P_W'(req.c);
  end

endmodule
